FILE: hw/rtl/ujse_pkg.sv
// Shared types, constants and helpers for the UTF-8 validating JSON string escaper.
package ujse_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
    localparam int unsigned TailMax    = 6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_U = 8'h75;

    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_CR  = 8'h0D;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_MIN_LEN4  = 21'h010000;
    localparam logic [20:0] CP_MIN_LEN3  = 21'h000800;
    localparam logic [20:0] CP_MIN_LEN2  = 21'h000080;

    // Output work for one accepted input beat: optional opening quote,
    // a number of EF BF BD replacements, then up to six literal bytes.
    typedef struct packed {
        logic                  open_quote;
        logic [2:0]            rep_cnt;
        logic [2:0]            tail_len;
        logic [TailMax-1:0][7:0] tail_bytes;
    } job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = 8'h30 + {4'h0, nib};
        else
            c = 8'h57 + {4'h0, nib};
        return c;
    endfunction

endpackage

FILE: hw/rtl/ujse_front.sv
// Front end: accepts input beats, tracks UTF-8 sequences and builds output jobs.
module ujse_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              end_of_string,
    input  logic              queue_full,
    output logic              in_ready,
    output logic              push,
    output ujse_pkg::job_t    job
);

    logic              inside_reg, inside_next;
    logic [2:0][7:0]   held_reg, held_next;
    logic [1:0]        held_cnt_reg, held_cnt_next;
    logic [2:0]        seq_len_reg, seq_len_next;
    logic [20:0]       cp_reg, cp_next;

    logic              accept;
    logic              fresh_go;
    logic [20:0]       cp_ext;
    logic              ill;
    logic [2:0]        rep;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        inside_next   = inside_reg;
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        seq_len_next  = seq_len_reg;
        cp_next       = cp_reg;
        job           = '0;
        fresh_go      = 1'b0;
        rep           = 3'd0;
        cp_ext        = {cp_reg[14:0], in_byte[5:0]};
        ill           = ((seq_len_reg == 3'd2) && (cp_ext < ujse_pkg::CP_MIN_LEN2)) ||
                        ((seq_len_reg == 3'd3) && (cp_ext < ujse_pkg::CP_MIN_LEN3)) ||
                        ((seq_len_reg == 3'd4) && (cp_ext < ujse_pkg::CP_MIN_LEN4)) ||
                        ((cp_ext >= ujse_pkg::CP_SURR_LO) &&
                         (cp_ext <= ujse_pkg::CP_SURR_HI)) ||
                        (cp_ext > ujse_pkg::CP_MAX);

        job.open_quote = !inside_reg;

        if (end_of_string)
        begin
            rep                = {1'b0, held_cnt_reg};
            job.tail_len       = 3'd1;
            job.tail_bytes[0]  = ujse_pkg::CH_QUOTE;
            inside_next        = 1'b0;
            held_cnt_next      = 2'd0;
            seq_len_next       = 3'd0;
            cp_next            = '0;
        end
        else
        begin
            inside_next = 1'b1;
            fresh_go    = 1'b1;
            if (held_cnt_reg != 2'd0)
            begin
                if (in_byte[7:6] == 2'b10)
                begin
                    fresh_go = 1'b0;
                    if (({1'b0, held_cnt_reg} + 3'd1) < seq_len_reg)
                    begin
                        held_next[held_cnt_reg] = in_byte;
                        held_cnt_next           = held_cnt_reg + 2'd1;
                        cp_next                 = cp_ext;
                    end
                    else
                    begin
                        if (ill)
                            rep = seq_len_reg;
                        else
                        begin
                            job.tail_len   = seq_len_reg;
                            job.tail_bytes[2:0] = held_reg;
                            job.tail_bytes[seq_len_reg - 3'd1] = in_byte;
                        end
                        held_cnt_next = 2'd0;
                        seq_len_next  = 3'd0;
                        cp_next       = '0;
                    end
                end
                else
                begin
                    // broken sequence: flush held bytes, then take this byte afresh
                    rep           = {1'b0, held_cnt_reg};
                    held_cnt_next = 2'd0;
                    seq_len_next  = 3'd0;
                    cp_next       = '0;
                end
            end

            if (fresh_go)
            begin
                if (!in_byte[7])
                begin
                    job.tail_len = 3'd2;
                    job.tail_bytes[0] = ujse_pkg::CH_BSLASH;
                    unique case (in_byte)
                        ujse_pkg::CH_QUOTE:  job.tail_bytes[1] = ujse_pkg::CH_QUOTE;
                        ujse_pkg::CH_BSLASH: job.tail_bytes[1] = ujse_pkg::CH_BSLASH;
                        ujse_pkg::BYTE_BS:   job.tail_bytes[1] = ujse_pkg::CH_LOWER_B;
                        ujse_pkg::BYTE_FF:   job.tail_bytes[1] = ujse_pkg::CH_LOWER_F;
                        ujse_pkg::BYTE_LF:   job.tail_bytes[1] = ujse_pkg::CH_LOWER_N;
                        ujse_pkg::BYTE_CR:   job.tail_bytes[1] = ujse_pkg::CH_LOWER_R;
                        ujse_pkg::BYTE_TAB:  job.tail_bytes[1] = ujse_pkg::CH_LOWER_T;
                        default:
                        begin
                            if (in_byte < 8'h20)
                            begin
                                job.tail_len      = 3'd6;
                                job.tail_bytes[1] = ujse_pkg::CH_LOWER_U;
                                job.tail_bytes[2] = ujse_pkg::CH_ZERO;
                                job.tail_bytes[3] = ujse_pkg::CH_ZERO;
                                job.tail_bytes[4] = ujse_pkg::hex_char(in_byte[7:4]);
                                job.tail_bytes[5] = ujse_pkg::hex_char(in_byte[3:0]);
                            end
                            else
                            begin
                                job.tail_len      = 3'd1;
                                job.tail_bytes[0] = in_byte;
                            end
                        end
                    endcase
                end
                else if (in_byte[7:5] == 3'b110)
                begin
                    seq_len_next  = 3'd2;
                    cp_next       = {16'd0, in_byte[4:0]};
                    held_next[0]  = in_byte;
                    held_cnt_next = 2'd1;
                end
                else if (in_byte[7:4] == 4'b1110)
                begin
                    seq_len_next  = 3'd3;
                    cp_next       = {17'd0, in_byte[3:0]};
                    held_next[0]  = in_byte;
                    held_cnt_next = 2'd1;
                end
                else if (in_byte[7:3] == 5'b11110)
                begin
                    seq_len_next  = 3'd4;
                    cp_next       = {18'd0, in_byte[2:0]};
                    held_next[0]  = in_byte;
                    held_cnt_next = 2'd1;
                end
                else
                    rep = rep + 3'd1;   // stray continuation or invalid lead
            end
        end
        job.rep_cnt = rep;
    end

    assign push = accept && (job.open_quote || (job.rep_cnt != 3'd0) || (job.tail_len != 3'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg   <= 1'b0;
            held_cnt_reg <= 2'd0;
            seq_len_reg  <= 3'd0;
            cp_reg       <= '0;
        end
        else if (accept)
        begin
            inside_reg   <= inside_next;
            held_cnt_reg <= held_cnt_next;
            seq_len_reg  <= seq_len_next;
            cp_reg       <= cp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

endmodule

FILE: hw/rtl/ujse_queue.sv
// Small job queue between front and back end.
module ujse_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ujse_pkg::job_t  push_job,
    input  logic            pop,
    output ujse_pkg::job_t  head_job,
    output logic            nonempty,
    output logic            full
);

    ujse_pkg::job_t                         mem_reg [ujse_pkg::QueueDepth];
    logic [ujse_pkg::QueuePtrW-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [ujse_pkg::QueueCntW-1:0]         count_reg;

    assign nonempty = (count_reg != '0);
    assign full     = (count_reg == ujse_pkg::QueueCntW'(ujse_pkg::QueueDepth));
    assign head_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: hw/rtl/ujse_back.sv
// Back end: walks the head job and drives the output register one byte a beat.
module ujse_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ujse_pkg::job_t  head_job,
    input  logic            job_avail,
    output logic            pop,
    output logic            out_valid,
    output logic [7:0]      out_byte,
    output logic            out_last,
    input  logic            out_ready
);

    typedef enum logic [1:0] {SEG_OPEN, SEG_REP, SEG_TAIL} seg_t;

    logic        open_done_reg, open_done_next;
    logic [2:0]  rep_idx_reg, rep_idx_next;
    logic [1:0]  rep_phase_reg, rep_phase_next;
    logic [2:0]  tail_idx_reg, tail_idx_next;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    seg_t        seg;
    logic        load;
    logic        emit;
    logic [7:0]  cur_byte;
    logic        cur_last;

    assign load = !valid_reg || out_ready;
    assign emit = load && job_avail;

    always_comb
    begin
        if (head_job.open_quote && !open_done_reg)
            seg = SEG_OPEN;
        else if (rep_idx_reg < head_job.rep_cnt)
            seg = SEG_REP;
        else
            seg = SEG_TAIL;
    end

    always_comb
    begin
        open_done_next = open_done_reg;
        rep_idx_next   = rep_idx_reg;
        rep_phase_next = rep_phase_reg;
        tail_idx_next  = tail_idx_reg;
        cur_byte       = ujse_pkg::CH_QUOTE;
        cur_last       = 1'b0;
        unique case (seg)
            SEG_OPEN:
            begin
                cur_byte       = ujse_pkg::CH_QUOTE;
                cur_last       = (head_job.rep_cnt == 3'd0) && (head_job.tail_len == 3'd0);
                open_done_next = 1'b1;
            end
            SEG_REP:
            begin
                case (rep_phase_reg)
                    2'd0:    cur_byte = ujse_pkg::REPL_B0;
                    2'd1:    cur_byte = ujse_pkg::REPL_B1;
                    default: cur_byte = ujse_pkg::REPL_B2;
                endcase
                cur_last = (rep_phase_reg == 2'd2) &&
                           ((rep_idx_reg + 3'd1) == head_job.rep_cnt) &&
                           (head_job.tail_len == 3'd0);
                if (rep_phase_reg == 2'd2)
                begin
                    rep_phase_next = 2'd0;
                    rep_idx_next   = rep_idx_reg + 3'd1;
                end
                else
                    rep_phase_next = rep_phase_reg + 2'd1;
            end
            SEG_TAIL:
            begin
                cur_byte      = head_job.tail_bytes[tail_idx_reg];
                cur_last      = (tail_idx_reg + 3'd1) == head_job.tail_len;
                tail_idx_next = tail_idx_reg + 3'd1;
            end
            default:
            begin
                cur_byte = ujse_pkg::CH_QUOTE;
                cur_last = 1'b0;
            end
        endcase
        // job done: rewind for the next one
        if (cur_last)
        begin
            open_done_next = 1'b0;
            rep_idx_next   = 3'd0;
            rep_phase_next = 2'd0;
            tail_idx_next  = 3'd0;
        end
    end

    assign pop       = emit && cur_last;
    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_done_reg <= 1'b0;
            rep_idx_reg   <= 3'd0;
            rep_phase_reg <= 2'd0;
            tail_idx_reg  <= 3'd0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                open_done_reg <= open_done_next;
                rep_idx_reg   <= rep_idx_next;
                rep_phase_reg <= rep_phase_next;
                tail_idx_reg  <= tail_idx_next;
            end
            if (load)
                valid_reg <= job_avail;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= cur_byte;
            last_reg <= cur_last;
        end
    end

endmodule

FILE: hw/rtl/utf8_validating_json_string_escaper_core.sv
// Top level of the UTF-8 validating JSON string escaper.
//
//  channel  | signals                          | content
//  ---------+----------------------------------+------------------------------------
//  s_ (in)  | s_tvalid s_tready s_tdata s_tuser| raw string byte, end-of-string flag
//  m_ (out) | m_tvalid m_tready m_tdata m_tlast| escaped output byte, last of beat's run
//
// One input beat per cycle is taken while the four-entry job queue has room.
// The back end emits one output byte per cycle while a job is queued and m_tready
// is high; a beat yields at most 15 bytes, and output is registered.
// Reset is asynchronous, active low; no clearing pass follows it.
// Either side may stall on its own; the queue absorbs the difference.
module utf8_validating_json_string_escaper_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    ujse_pkg::job_t push_job;
    ujse_pkg::job_t head_job;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_nonempty;

    ujse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_byte       (s_tdata),
        .end_of_string (s_tuser),
        .queue_full    (q_full),
        .in_ready      (s_tready),
        .push          (q_push),
        .job           (push_job)
    );

    ujse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .nonempty (q_nonempty),
        .full     (q_full)
    );

    ujse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .job_avail (q_nonempty),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_nonempty)
        else $error("job popped from an empty queue");

    a_end_beat_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> q_nonempty)
        else $error("end-of-string beat left no job for the closing quote");

endmodule
